// ===== design/ptec_pkg.sv =====
// ----------------------------------------------------------------------------
// ptec_pkg: shared types and constants
// Codes, fixed-point formats and the side data that travels with each hit.
// ----------------------------------------------------------------------------
package ptec_pkg;

    // Fraction bits of coefficients and of the energy result.
    localparam int COEF_FRAC_BITS = 16;

    // Request operation codes.
    localparam logic OP_WRITE = 1'b0;
    localparam logic OP_CONV  = 1'b1;

    // Coefficient select codes.
    localparam logic [1:0] COEF_A = 2'd0;
    localparam logic [1:0] COEF_B = 2'd1;
    localparam logic [1:0] COEF_C = 2'd2;
    localparam logic [1:0] COEF_T = 2'd3;

    // Result status codes.
    localparam logic [1:0] STAT_OK    = 2'd0;
    localparam logic [1:0] STAT_DISC  = 2'd1;
    localparam logic [1:0] STAT_AZERO = 2'd2;
    localparam logic [1:0] STAT_SAT   = 2'd3;

    // Data carried alongside a conversion through the pipeline.
    typedef struct packed {
        logic               done;    // result already settled
        logic [1:0]         status;  // settled status
        logic               a_neg;   // sign of coefficient a
        logic [32:0]        dvs;     // divisor 2*|a|
        logic signed [63:0] nbase;   // t*a + ToT - b at 2F fraction bits
    } t_side;

endpackage

// ===== design/pixel_tot_to_energy_calibration_unit.sv =====
// ----------------------------------------------------------------------------
// pixel_tot_to_energy_calibration_unit: ToT to energy conversion
// Per-pixel surrogate-function inversion against four coefficient tables.
// ----------------------------------------------------------------------------
// Usage:
//   A request is taken at each rising edge with start high; busy stays low,
//   so one request may be issued every cycle.
//   op = write stores coef_value into the table picked by coef_select at
//   pixel (x, y); it produces no result. Coordinates outside the sensor are
//   ignored.
//   op = convert reads the pixel's four coefficients and returns energy and
//   status on o_energy/o_status, marked by o_valid for one cycle. Results
//   leave in request order.
//   The result passes the memory read, the product and discriminant stages,
//   the 64-stage square root (one root bit per stage), the numerator register,
//   the 32-stage divider (one quotient bit per stage) and the output register.
//   A write takes effect for any conversion issued in a later cycle.
//   Reset clears only the pipeline valid flags; table contents are undefined
//   until written. There is no back pressure: results are never held.
// ----------------------------------------------------------------------------
module pixel_tot_to_energy_calibration_unit #(
    parameter int SENSOR_SIDE = 256
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        start,
    output logic        busy,
    input  logic        i_op,
    input  logic [7:0]  i_pixel_x,
    input  logic [7:0]  i_pixel_y,
    input  logic [9:0]  i_tot,
    input  logic [1:0]  i_coef_select,
    input  logic [31:0] i_coef_value,
    output logic        o_valid,
    output logic [31:0] o_energy,
    output logic [1:0]  o_status
);

    localparam int AW = $clog2(SENSOR_SIDE * SENSOR_SIDE);

    logic               in_range;
    logic [19:0]        idx_full;
    logic [AW-1:0]      addr;
    logic               we;
    logic               r_v1;
    logic               r_oob1;
    logic [9:0]         r_tot1;
    logic [31:0]        ca, cb, cc, ct;
    logic               dv, sv;
    logic [127:0]       dd;
    logic [63:0]        root;
    ptec_pkg::t_side    dside, sside;

    assign busy = 1'b0;

    // Address decode for the request.
    always_comb begin
        in_range = ({3'b000, i_pixel_x} < 11'(SENSOR_SIDE)) &&
                   ({3'b000, i_pixel_y} < 11'(SENSOR_SIDE));
        idx_full = 20'(i_pixel_x) + 20'(i_pixel_y) * 20'(SENSOR_SIDE);
        addr     = idx_full[AW-1:0];
        we       = start && !busy && (i_op == ptec_pkg::OP_WRITE) && in_range;
    end

    ptec_coef_mem #(.AW(AW)) u_mem (
        .i_clk   (i_clk),
        .i_we    (we),
        .i_sel   (i_coef_select),
        .i_addr  (addr),
        .i_wdata (i_coef_value),
        .o_a     (ca),
        .o_b     (cb),
        .o_c     (cc),
        .o_t     (ct)
    );

    // Conversion request flags aligned with the memory read data.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v1 <= 1'b0;
        end else begin
            r_v1 <= start && !busy && (i_op == ptec_pkg::OP_CONV);
        end
    end

    always_ff @(posedge i_clk) begin
        r_oob1 <= !in_range;
        r_tot1 <= i_tot;
    end

    ptec_disc u_disc (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_vld   (r_v1),
        .i_oob   (r_oob1),
        .i_tot   (r_tot1),
        .i_a     (ca),
        .i_b     (cb),
        .i_c     (cc),
        .i_t     (ct),
        .o_vld   (dv),
        .o_dd    (dd),
        .o_side  (dside)
    );

    ptec_isqrt u_isqrt (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_vld   (dv),
        .i_dd    (dd),
        .i_side  (dside),
        .o_vld   (sv),
        .o_root  (root),
        .o_side  (sside)
    );

    ptec_div u_div (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_vld    (sv),
        .i_root   (root),
        .i_side   (sside),
        .o_vld    (o_valid),
        .o_energy (o_energy),
        .o_status (o_status)
    );

`ifndef NO_ASSERTIONS
    // Every conversion request yields a result after the pipeline latency.
    a_conv_result : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (start && !busy && i_op == ptec_pkg::OP_CONV) |-> ##104 o_valid)
        else $error("conversion request lost");

    // A cycle without a conversion request yields no result.
    a_no_extra : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !(start && !busy && i_op == ptec_pkg::OP_CONV) |-> ##104 !o_valid)
        else $error("result without a conversion request");

    // Zero-a and non-positive discriminant results carry zero energy.
    a_zero_energy : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && (o_status == ptec_pkg::STAT_AZERO ||
                     o_status == ptec_pkg::STAT_DISC)) |-> (o_energy == 32'd0))
        else $error("nonzero energy on an error status");
`endif

endmodule

// ===== design/ptec_coef_mem.sv =====
// ----------------------------------------------------------------------------
// ptec_coef_mem: per-pixel coefficient storage
// Four synchronous tables for a, b, c and t with a registered read.
// ----------------------------------------------------------------------------
module ptec_coef_mem #(
    parameter int AW = 16
) (
    input  logic          i_clk,
    input  logic          i_we,
    input  logic [1:0]    i_sel,
    input  logic [AW-1:0] i_addr,
    input  logic [31:0]   i_wdata,
    output logic [31:0]   o_a,
    output logic [31:0]   o_b,
    output logic [31:0]   o_c,
    output logic [31:0]   o_t
);

    logic [31:0] mem_a [0:(2**AW)-1];
    logic [31:0] mem_b [0:(2**AW)-1];
    logic [31:0] mem_c [0:(2**AW)-1];
    logic [31:0] mem_t [0:(2**AW)-1];
    logic [31:0] r_a, r_b, r_c, r_t;

    // Writes go to the selected table; reads of all four every cycle.
    always_ff @(posedge i_clk) begin
        if (i_we && i_sel == ptec_pkg::COEF_A) begin
            mem_a[i_addr] <= i_wdata;
        end
        r_a <= mem_a[i_addr];
    end

    always_ff @(posedge i_clk) begin
        if (i_we && i_sel == ptec_pkg::COEF_B) begin
            mem_b[i_addr] <= i_wdata;
        end
        r_b <= mem_b[i_addr];
    end

    always_ff @(posedge i_clk) begin
        if (i_we && i_sel == ptec_pkg::COEF_C) begin
            mem_c[i_addr] <= i_wdata;
        end
        r_c <= mem_c[i_addr];
    end

    always_ff @(posedge i_clk) begin
        if (i_we && i_sel == ptec_pkg::COEF_T) begin
            mem_t[i_addr] <= i_wdata;
        end
        r_t <= mem_t[i_addr];
    end

    assign o_a = r_a;
    assign o_b = r_b;
    assign o_c = r_c;
    assign o_t = r_t;

endmodule

// ===== design/ptec_disc.sv =====
// ----------------------------------------------------------------------------
// ptec_disc: discriminant pipeline
// Five stages forming D = (b + t*a - ToT)^2 + 4ac and the numerator base.
// ----------------------------------------------------------------------------
module ptec_disc (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_vld,
    input  logic              i_oob,
    input  logic [9:0]        i_tot,
    input  logic [31:0]       i_a,
    input  logic [31:0]       i_b,
    input  logic [31:0]       i_c,
    input  logic [31:0]       i_t,
    output logic              o_vld,
    output logic [127:0]      o_dd,
    output ptec_pkg::t_side   o_side
);

    localparam int F = ptec_pkg::COEF_FRAC_BITS;

    // Stage A registers: products.
    logic               r_va;
    logic               r_oob_a;
    logic [9:0]         r_tot_a;
    logic signed [31:0] r_a_a, r_b_a;
    logic signed [63:0] r_ta, r_ac;

    // Stage B registers.
    logic               r_vb;
    logic [63:0]        r_umag;
    logic [127:0]       r_m4_b;
    logic               r_acneg_b;
    ptec_pkg::t_side    r_side_b;

    // Stage C registers.
    logic               r_vc;
    logic [63:0]        r_p00, r_pmid, r_p11;
    logic [127:0]       r_m4_c;
    logic               r_acneg_c;
    ptec_pkg::t_side    r_side_c;

    // Stage D registers.
    logic               r_vd;
    logic [127:0]       r_sq, r_m4_d;
    logic               r_acneg_d;
    ptec_pkg::t_side    r_side_d;

    // Stage E registers.
    logic               r_ve;
    logic [127:0]       r_dd;
    ptec_pkg::t_side    r_side_e;

    logic signed [63:0] b_sh, tot_sh, u, nb;
    logic [63:0]        ac_mag;
    logic [31:0]        a_mag;
    ptec_pkg::t_side    n_side_b, n_side_e;
    logic [127:0]       n_dd;
    logic               dpos;

    // Valid pipeline.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_va <= 1'b0;
            r_vb <= 1'b0;
            r_vc <= 1'b0;
            r_vd <= 1'b0;
            r_ve <= 1'b0;
        end else begin
            r_va <= i_vld;
            r_vb <= r_va;
            r_vc <= r_vb;
            r_vd <= r_vc;
            r_ve <= r_vd;
        end
    end

    // Stage A: the two coefficient products.
    always_ff @(posedge i_clk) begin
        r_oob_a <= i_oob;
        r_tot_a <= i_tot;
        r_a_a   <= signed'(i_a);
        r_b_a   <= signed'(i_b);
        r_ta    <= signed'(i_t) * signed'(i_a);
        r_ac    <= signed'(i_a) * signed'(i_c);
    end

    // Stage B: u and the numerator base, magnitudes, early zero-a and out-of-range check.
    always_comb begin
        b_sh   = {{(32-F){r_b_a[31]}}, r_b_a, {F{1'b0}}};
        tot_sh = {{(54-2*F){1'b0}}, r_tot_a, {(2*F){1'b0}}};
        u      = r_ta + b_sh - tot_sh;
        nb     = r_ta + tot_sh - b_sh;
        ac_mag = r_ac[63] ? (~r_ac + 64'd1) : r_ac;
        a_mag  = r_a_a[31] ? (~r_a_a + 32'd1) : r_a_a;
        n_side_b.done   = r_oob_a || (r_a_a == 32'sd0);
        n_side_b.status = ptec_pkg::STAT_AZERO;
        n_side_b.a_neg  = r_a_a[31];
        n_side_b.dvs    = {a_mag, 1'b0};
        n_side_b.nbase  = nb;
    end

    always_ff @(posedge i_clk) begin
        r_umag    <= u[63] ? (~u + 64'd1) : u;
        r_m4_b    <= {{(62-2*F){1'b0}}, ac_mag, {(2*F+2){1'b0}}};
        r_acneg_b <= r_ac[63];
        r_side_b  <= n_side_b;
    end

    // Stage C: partial products of u squared.
    always_ff @(posedge i_clk) begin
        r_p00     <= r_umag[31:0] * r_umag[31:0];
        r_pmid    <= r_umag[31:0] * r_umag[63:32];
        r_p11     <= r_umag[63:32] * r_umag[63:32];
        r_m4_c    <= r_m4_b;
        r_acneg_c <= r_acneg_b;
        r_side_c  <= r_side_b;
    end

    // Stage D: sum of the partial products.
    always_ff @(posedge i_clk) begin
        r_sq      <= 128'(r_p00) + (128'(r_pmid) << 33) + {r_p11, 64'd0};
        r_m4_d    <= r_m4_c;
        r_acneg_d <= r_acneg_c;
        r_side_d  <= r_side_c;
    end

    // Stage E: discriminant and its sign check.
    always_comb begin
        n_side_e = r_side_d;
        if (r_acneg_d) begin
            n_dd = r_sq - r_m4_d;
            dpos = r_sq > r_m4_d;
        end else begin
            n_dd = r_sq + r_m4_d;
            dpos = n_dd != 128'd0;
        end
        if (!r_side_d.done && !dpos) begin
            n_side_e.done   = 1'b1;
            n_side_e.status = ptec_pkg::STAT_DISC;
        end
    end

    always_ff @(posedge i_clk) begin
        r_dd     <= n_dd;
        r_side_e <= n_side_e;
    end

    assign o_vld  = r_ve;
    assign o_dd   = r_dd;
    assign o_side = r_side_e;

endmodule

// ===== design/ptec_isqrt.sv =====
// ----------------------------------------------------------------------------
// ptec_isqrt: pipelined integer square root
// One result bit per stage, floor root of a 128-bit value in 64 stages.
// ----------------------------------------------------------------------------
module ptec_isqrt (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_vld,
    input  logic [127:0]      i_dd,
    input  ptec_pkg::t_side   i_side,
    output logic              o_vld,
    output logic [63:0]       o_root,
    output ptec_pkg::t_side   o_side
);

    localparam int NS = 64;

    logic              r_vld  [0:NS];
    logic [127:0]      r_rem  [0:NS];
    logic [63:0]       r_root [0:NS];
    ptec_pkg::t_side   r_side [0:NS];

    // Stage inputs.
    always_comb begin
        r_vld[0]  = i_vld;
        r_rem[0]  = i_dd;
        r_root[0] = 64'd0;
        r_side[0] = i_side;
    end

    // Each stage tries one root bit: keeps rem = D - root^2.
    for (genvar k = 0; k < NS; k++) begin : g_stage
        localparam int I = NS - 1 - k;
        logic [127:0] trial;

        always_comb begin
            trial = (128'(r_root[k]) << (I + 1)) | (128'd1 << (2 * I));
        end

        always_ff @(posedge i_clk) begin
            if (!i_rst_n) begin
                r_vld[k+1] <= 1'b0;
            end else begin
                r_vld[k+1] <= r_vld[k];
            end
        end

        always_ff @(posedge i_clk) begin
            r_side[k+1] <= r_side[k];
            if (trial <= r_rem[k]) begin
                r_rem[k+1]  <= r_rem[k] - trial;
                r_root[k+1] <= r_root[k] | (64'd1 << I);
            end else begin
                r_rem[k+1]  <= r_rem[k];
                r_root[k+1] <= r_root[k];
            end
        end
    end

    assign o_vld  = r_vld[NS];
    assign o_root = r_root[NS];
    assign o_side = r_side[NS];

endmodule

// ===== design/ptec_div.sv =====
// ----------------------------------------------------------------------------
// ptec_div: numerator, range checks and pipelined divider
// Forms the numerator, settles sign and saturation, then divides by 2|a|.
// ----------------------------------------------------------------------------
module ptec_div (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_vld,
    input  logic [63:0]       i_root,
    input  ptec_pkg::t_side   i_side,
    output logic              o_vld,
    output logic [31:0]       o_energy,
    output logic [1:0]        o_status
);

    localparam int NQ = 32;

    // Numerator stage outputs feed divider stage zero.
    logic              r_vld  [0:NQ];
    logic [63:0]       r_rem  [0:NQ];
    logic [31:0]       r_quo  [0:NQ];
    logic [31:0]       r_fix  [0:NQ];
    ptec_pkg::t_side   r_side [0:NQ];

    logic              r_ov;
    logic [31:0]       r_energy;
    logic [1:0]        r_status;

    logic signed [65:0] num;
    logic [65:0]        mag;
    logic [65:0]        lim;
    ptec_pkg::t_side    n_side;
    logic [31:0]        n_fix;

    // Numerator, sign against a, and saturation limit.
    always_comb begin
        num    = {{2{i_side.nbase[63]}}, i_side.nbase} + signed'({2'b00, i_root});
        mag    = num[65] ? (~num + 66'd1) : num;
        lim    = {1'b0, i_side.dvs, 32'd0};
        n_side = i_side;
        n_fix  = 32'd0;
        if (!i_side.done) begin
            if (num == 66'sd0) begin
                n_side.done   = 1'b1;
                n_side.status = ptec_pkg::STAT_OK;
            end else if (num[65] != i_side.a_neg) begin
                n_side.done   = 1'b1;
                n_side.status = ptec_pkg::STAT_SAT;
            end else if (mag >= lim) begin
                n_side.done   = 1'b1;
                n_side.status = ptec_pkg::STAT_SAT;
                n_fix         = 32'hFFFF_FFFF;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld[0] <= 1'b0;
        end else begin
            r_vld[0] <= i_vld;
        end
    end

    always_ff @(posedge i_clk) begin
        r_rem[0]  <= mag[63:0];
        r_quo[0]  <= 32'd0;
        r_fix[0]  <= n_fix;
        r_side[0] <= n_side;
    end

    // Restoring division, one quotient bit per stage.
    for (genvar k = 0; k < NQ; k++) begin : g_stage
        localparam int I = NQ - 1 - k;
        logic [63:0] dsh;

        always_comb begin
            dsh = 64'(r_side[k].dvs) << I;
        end

        always_ff @(posedge i_clk) begin
            if (!i_rst_n) begin
                r_vld[k+1] <= 1'b0;
            end else begin
                r_vld[k+1] <= r_vld[k];
            end
        end

        always_ff @(posedge i_clk) begin
            r_fix[k+1]  <= r_fix[k];
            r_side[k+1] <= r_side[k];
            if (r_rem[k] >= dsh) begin
                r_rem[k+1] <= r_rem[k] - dsh;
                r_quo[k+1] <= r_quo[k] | (32'd1 << I);
            end else begin
                r_rem[k+1] <= r_rem[k];
                r_quo[k+1] <= r_quo[k];
            end
        end
    end

    // Result register: settled value or quotient.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ov <= 1'b0;
        end else begin
            r_ov <= r_vld[NQ];
        end
    end

    always_ff @(posedge i_clk) begin
        r_energy <= r_side[NQ].done ? r_fix[NQ] : r_quo[NQ];
        r_status <= r_side[NQ].done ? r_side[NQ].status : ptec_pkg::STAT_OK;
    end

    assign o_vld    = r_ov;
    assign o_energy = r_energy;
    assign o_status = r_status;

endmodule

// ===== bench/ptec_checker.sv =====
// ----------------------------------------------------------------------------
// ptec_checker: prediction and checking for the ToT to energy unit
// Watches requests and results, keeps its own copy of the coefficient tables,
// predicts each conversion and compares results in request order.
// ----------------------------------------------------------------------------
module ptec_checker (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_start,
    input  logic        i_busy,
    input  logic        i_op,
    input  logic [7:0]  i_pixel_x,
    input  logic [7:0]  i_pixel_y,
    input  logic [9:0]  i_tot,
    input  logic [1:0]  i_coef_select,
    input  logic [31:0] i_coef_value,
    input  logic        i_valid,
    input  logic [31:0] i_energy,
    input  logic [1:0]  i_status,
    output int          o_errors,
    output int          o_pending
);
    timeunit 1ns;
    timeprecision 1ps;

    typedef struct {
        logic [31:0] energy;
        logic [1:0]  status;
    } t_energy_result;

    logic [31:0]    coef_tab [0:3][0:65535];
    t_energy_result energy_q[$];
    int             mismatches = 0;

    // Exact inversion of the surrogate function at the block's fixed-point widths.
    function automatic void calc_energy(input logic [31:0] ra, input logic [31:0] rb,
                                        input logic [31:0] rc, input logic [31:0] rt,
                                        input logic [9:0] tot,
                                        output logic [31:0] energy,
                                        output logic [1:0] status);
        logic signed [127:0] a, b, c, t, tt, u, ac, nbase, num;
        logic [127:0]        sq, m4, dd, umag, acmag, nmag, dvs, lim, cc;
        logic [63:0]         root, cand;
        logic                neg;
        a  = {{96{ra[31]}}, ra};
        b  = {{96{rb[31]}}, rb};
        c  = {{96{rc[31]}}, rc};
        t  = {{96{rt[31]}}, rt};
        tt = {118'b0, tot};
        energy = '0;
        if (a == 0) begin
            status = ptec_pkg::STAT_AZERO;
            return;
        end
        u = (b <<< 16) + t * a - (tt <<< 32);
        umag = (u < 0) ? -u : u;
        sq = umag * umag;
        ac = a * c;
        acmag = (ac < 0) ? -ac : ac;
        m4 = acmag << 34;
        if (ac >= 0) begin
            dd = sq + m4;
            if (dd == 0) begin
                status = ptec_pkg::STAT_DISC;
                return;
            end
        end else begin
            if (sq <= m4) begin
                status = ptec_pkg::STAT_DISC;
                return;
            end
            dd = sq - m4;
        end
        // Floor square root, one bit at a time.
        root = '0;
        for (int bit_i = 63; bit_i >= 0; bit_i--) begin
            cand = root | (64'd1 << bit_i);
            cc = {64'b0, cand};
            if (cc * cc <= dd) root = cand;
        end
        nbase = t * a + (tt <<< 32) - (b <<< 16);
        num = nbase + $signed({64'b0, root});
        if (num == 0) begin
            status = ptec_pkg::STAT_OK;
            return;
        end
        neg = (num < 0) != (a < 0);
        if (neg) begin
            status = ptec_pkg::STAT_SAT;
            return;
        end
        nmag = (num < 0) ? -num : num;
        dvs = (a < 0) ? -(a <<< 1) : (a <<< 1);
        lim = dvs << 32;
        if (nmag >= lim) begin
            energy = '1;
            status = ptec_pkg::STAT_SAT;
            return;
        end
        cc = {64'b0, nmag[63:0]} / dvs;
        energy = cc[31:0];
        status = ptec_pkg::STAT_OK;
    endfunction

    assign o_pending = energy_q.size();
    assign o_errors  = mismatches;

    // Track accepted requests and check each result against the oldest prediction.
    always @(posedge i_clk) begin
        int             idx;
        t_energy_result want;
        if (i_rst_n) begin
            if (i_valid) begin
                if (energy_q.size() == 0) begin
                    mismatches <= mismatches + 1;
                    if (mismatches < 10)
                        $display("[%0t] unexpected result energy=%h status=%0d",
                                 $realtime, i_energy, i_status);
                end else begin
                    want = energy_q.pop_front();
                    if (want.energy !== i_energy || want.status !== i_status) begin
                        mismatches <= mismatches + 1;
                        if (mismatches < 10)
                            $display({"[%0t] mismatch: expected energy=%h status=%0d,",
                                      " got energy=%h status=%0d"},
                                     $realtime, want.energy, want.status,
                                     i_energy, i_status);
                    end
                end
            end
            if (i_start && !i_busy) begin
                idx = int'({i_pixel_y, i_pixel_x});
                if (i_op == ptec_pkg::OP_WRITE) begin
                    coef_tab[i_coef_select][idx] = i_coef_value;
                end else begin
                    calc_energy(coef_tab[ptec_pkg::COEF_A][idx],
                                coef_tab[ptec_pkg::COEF_B][idx],
                                coef_tab[ptec_pkg::COEF_C][idx],
                                coef_tab[ptec_pkg::COEF_T][idx],
                                i_tot, want.energy, want.status);
                    energy_q.push_back(want);
                end
            end
        end
    end

endmodule

// ===== bench/tb_pixel_tot_to_energy_calibration_unit.sv =====
// ----------------------------------------------------------------------------
// tb_pixel_tot_to_energy_calibration_unit: testbench top
// Loads coefficients for a pool of pixels, issues directed and random
// conversions with random gaps, and reports the checker's verdict.
// ----------------------------------------------------------------------------
module tb_pixel_tot_to_energy_calibration_unit;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int POOL = 16;

    logic        i_clk = 1'b0;
    logic        i_rst_n = 1'b0;
    logic        start = 1'b0;
    logic        busy;
    logic        i_op = ptec_pkg::OP_WRITE;
    logic [7:0]  i_pixel_x = '0;
    logic [7:0]  i_pixel_y = '0;
    logic [9:0]  i_tot = '0;
    logic [1:0]  i_coef_select = ptec_pkg::COEF_A;
    logic [31:0] i_coef_value = '0;
    logic        o_valid;
    logic [31:0] o_energy;
    logic [1:0]  o_status;
    int          n_errors;
    int          n_pending;

    logic [7:0]  pool_x [POOL];
    logic [7:0]  pool_y [POOL];
    logic [3:0]  pool_mask [POOL];

    always #1 i_clk = ~i_clk;

    pixel_tot_to_energy_calibration_unit DUT (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .start(start), .busy(busy),
        .i_op(i_op), .i_pixel_x(i_pixel_x), .i_pixel_y(i_pixel_y), .i_tot(i_tot),
        .i_coef_select(i_coef_select), .i_coef_value(i_coef_value),
        .o_valid(o_valid), .o_energy(o_energy), .o_status(o_status)
    );

    ptec_checker u_checker (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_start(start), .i_busy(busy),
        .i_op(i_op), .i_pixel_x(i_pixel_x), .i_pixel_y(i_pixel_y), .i_tot(i_tot),
        .i_coef_select(i_coef_select), .i_coef_value(i_coef_value),
        .i_valid(o_valid), .i_energy(o_energy), .i_status(o_status),
        .o_errors(n_errors), .o_pending(n_pending)
    );

    // Issue one request after a random gap and wait until it is taken.
    task automatic send_request(input logic op, input logic [7:0] x, input logic [7:0] y,
                                input logic [9:0] tot, input logic [1:0] sel,
                                input logic [31:0] val);
        int gap;
        gap = $urandom_range(0, 3);
        if ($urandom_range(0, 7) == 0) gap = 0;
        if (gap > 0) begin
            start <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        start         <= 1'b1;
        i_op          <= op;
        i_pixel_x     <= x;
        i_pixel_y     <= y;
        i_tot         <= tot;
        i_coef_select <= sel;
        i_coef_value  <= val;
        @(negedge i_clk);
        while (busy) @(negedge i_clk);
        @(posedge i_clk);
    endtask

    task automatic load_coef(input int slot, input logic [1:0] sel, input logic [31:0] val);
        send_request(ptec_pkg::OP_WRITE, pool_x[slot], pool_y[slot], '0, sel, val);
        pool_mask[slot][sel] = 1'b1;
    endtask

    task automatic load_pixel(input int slot, input logic [31:0] a, input logic [31:0] b,
                              input logic [31:0] c, input logic [31:0] t);
        load_coef(slot, ptec_pkg::COEF_A, a);
        load_coef(slot, ptec_pkg::COEF_B, b);
        load_coef(slot, ptec_pkg::COEF_C, c);
        load_coef(slot, ptec_pkg::COEF_T, t);
    endtask

    // Coefficient mix: half physically plausible values, the rest raw, zero and extreme words.
    function automatic logic [31:0] pick_coef(input logic [1:0] sel);
        int          kind;
        logic [31:0] v;
        kind = $urandom_range(0, 9);
        if (kind < 5) begin
            v = $urandom_range(0, 32'h000F_FFFF);
            if (sel == ptec_pkg::COEF_A) v = $urandom_range(32'h0000_1000, 32'h0004_0000);
            if ($urandom_range(0, 3) == 0) v = -v;
        end else if (kind < 8) begin
            v = $urandom();
        end else if (kind == 8) begin
            v = '0;
        end else begin
            case ($urandom_range(0, 3))
                0: v = 32'h8000_0000;
                1: v = 32'h7FFF_FFFF;
                2: v = 32'hFFFF_FFFF;
                default: v = 32'h0000_0001;
            endcase
        end
        return v;
    endfunction

    // Stimulus: directed corner cases, then random writes and conversions.
    initial begin
        int         slot;
        logic [1:0] sel;
        pool_x[0] = 8'h00;
        pool_y[0] = 8'h00;
        pool_x[1] = 8'hFF;
        pool_y[1] = 8'hFF;
        for (int i = 2; i < POOL; i++) begin
            pool_x[i] = 8'($urandom());
            pool_y[i] = 8'($urandom());
        end
        for (int i = 0; i < POOL; i++) pool_mask[i] = '0;
        repeat (12) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // Plausible calibration at a corner pixel, with ToT extremes.
        load_pixel(0, 32'h0001_8000, 32'h0014_0000, 32'h0064_0000, 32'h0002_0000);
        send_request(ptec_pkg::OP_CONV, pool_x[0], pool_y[0], 10'd0, ptec_pkg::COEF_A, '0);
        send_request(ptec_pkg::OP_CONV, pool_x[0], pool_y[0], 10'd1023, ptec_pkg::COEF_A, '0);
        // Coefficient a zero.
        load_pixel(1, 32'h0000_0000, 32'h0001_0000, 32'h0001_0000, 32'h0001_0000);
        send_request(ptec_pkg::OP_CONV, pool_x[1], pool_y[1], 10'd5, ptec_pkg::COEF_A, '0);
        // Discriminant negative, then exactly zero.
        load_pixel(1, 32'h0001_0000, 32'h0000_0000, 32'hFFF0_0000, 32'h0000_0000);
        send_request(ptec_pkg::OP_CONV, pool_x[1], pool_y[1], 10'd0, ptec_pkg::COEF_A, '0);
        load_pixel(1, 32'h0001_0000, 32'h0000_0000, 32'h0000_0000, 32'h0000_0000);
        send_request(ptec_pkg::OP_CONV, pool_x[1], pool_y[1], 10'd0, ptec_pkg::COEF_A, '0);
        // Negative quotient clamps to zero.
        load_coef(1, ptec_pkg::COEF_A, 32'hFFFF_0000);
        load_coef(1, ptec_pkg::COEF_C, 32'h0001_0000);
        send_request(ptec_pkg::OP_CONV, pool_x[1], pool_y[1], 10'd100, ptec_pkg::COEF_A, '0);
        // Tiny a drives the quotient above the range.
        load_pixel(1, 32'h0000_0001, 32'h8000_0000, 32'h7FFF_FFFF, 32'h7FFF_FFFF);
        send_request(ptec_pkg::OP_CONV, pool_x[1], pool_y[1], 10'd1023, ptec_pkg::COEF_A, '0);
        // Extreme coefficient words.
        load_pixel(0, 32'h8000_0000, 32'h7FFF_FFFF, 32'h8000_0000, 32'h8000_0000);
        send_request(ptec_pkg::OP_CONV, pool_x[0], pool_y[0], 10'd512, ptec_pkg::COEF_A, '0);

        for (int i = 2; i < POOL; i++)
            load_pixel(i, pick_coef(ptec_pkg::COEF_A), pick_coef(ptec_pkg::COEF_B),
                       pick_coef(ptec_pkg::COEF_C), pick_coef(ptec_pkg::COEF_T));

        for (int n = 0; n < 900; n++) begin
            slot = $urandom_range(0, POOL - 1);
            sel  = 2'($urandom_range(0, 3));
            case ($urandom_range(0, 9))
                0, 1: load_coef(slot, sel, pick_coef(sel));
                // Writes to random pixels.
                2: send_request(ptec_pkg::OP_WRITE, 8'($urandom()), 8'($urandom()),
                                10'($urandom()), sel, $urandom());
                default: begin
                    if (pool_mask[slot] == 4'hF)
                        send_request(ptec_pkg::OP_CONV, pool_x[slot], pool_y[slot],
                                     10'($urandom()), 2'($urandom()), $urandom());
                end
            endcase
        end
        start <= 1'b0;

        while (n_pending != 0) @(posedge i_clk);
        repeat (120) @(posedge i_clk);
        if (n_errors == 0 && n_pending == 0) begin
            $display("Testbench completed without errors");
        end else begin
            $display("Testbench completed WITH ERRORS");
        end
        $finish;
    end

    // Watchdog for a hung run.
    initial begin
        #200000;
        $display("Testbench completed WITH ERRORS");
        $finish;
    end

endmodule
